// ----- hdl/cfmr_pkg.sv -----
// Package for the CRC-16 framed message receiver.
// Holds frame constants, result codes, port widths and the byte-wise CRC function.
// No dependencies.
package cfmr_pkg;

  localparam logic [7:0]  START_BYTE = 8'h1B;
  localparam logic [7:0]  TOKEN_BYTE = 8'h0E;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam int          HEADER_LEN = 8;
  localparam int          MAX_BODY_DEF = 4096;

  localparam int          CFG_W      = 13;
  localparam logic [12:0] CFG_RESET  = 13'd4096;
  localparam int          IN_DATA_W  = 8;
  localparam int          OUT_DATA_W = 64;
  localparam int          OUT_USER_W = 3;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_ERROR  = 2'd1,
    ST_DONE   = 2'd2
  } status_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- hdl/crc16_framed_message_receiver.sv -----
// Top level of the CRC-16 framed message receiver: input register, frame decode, result register.
// Depends on cfmr_pkg.
//
// channel   dir  handshake               payload
// in_       in   in_tvalid / in_tready   tdata: rx_byte
// out_      out  out_tvalid / out_tready tuser: status, body_valid; tdata: offset..error_position
// cfg_      in   cfg_wr_en               cfg_wr_data: max_body_size
//
// One byte per cycle sustained while the result side does not stall; each byte is decoded
// and checked, and header and body bytes are folded into the CRC, in the combinational logic
// between the input register and the result register. Reset (rst_n low, synchronous) empties
// both registers and returns to the start-byte search. A stalled result register holds
// the input register, which in turn drops in_tready.
module crc16_framed_message_receiver #(
  parameter int MAX_BODY = cfmr_pkg::MAX_BODY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cfmr_pkg::IN_DATA_W-1:0]    in_tdata,   // [7:0] rx_byte
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [11:0] body_offset, [19:12] body_byte, [35:20] sequence_number,
  // [48:36] body_length, [61:49] error_position, [63:62] zero
  output logic [cfmr_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [cfmr_pkg::OUT_USER_W-1:0]   out_tuser,  // [1:0] status, [2] body_valid
  input  logic                              cfg_wr_en,
  input  logic [cfmr_pkg::CFG_W-1:0]        cfg_wr_data
);
  import cfmr_pkg::*;

  localparam int LIM_MAX = (MAX_BODY < 8191) ? MAX_BODY : 8191;
  localparam int POS_W   = $clog2(HEADER_LEN + LIM_MAX + 3);
  localparam logic [16:0]      MAX_BODY_W = 17'(MAX_BODY);
  localparam logic [POS_W-1:0] HDR        = POS_W'(HEADER_LEN);

  logic [12:0]      max_r;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [12:0]      size_r, size_nxt;
  logic             hi_r, hi_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [15:0]      rcrc_r, rcrc_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [12:0]      err_r, err_nxt;

  logic             s1_v_r;
  logic [7:0]       s1_byte_r;
  logic             out_v_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic             adv;
  logic             fire;
  logic [7:0]       b;
  logic [POS_W-1:0] pos_end;
  logic             in_body;
  logic             ok;
  logic             crc_fold;
  logic             done;
  status_t          status;
  logic [11:0]      boff;
  logic [7:0]       bval;

  assign adv       = !out_v_r || out_tready;
  assign fire      = s1_v_r && adv;
  assign in_tready = !s1_v_r || adv;
  assign b         = s1_byte_r;
  assign pos_end   = HDR + POS_W'(size_r);
  assign in_body   = (pos_r >= HDR) && (pos_r < pos_end);

  always_comb begin
    pos_nxt  = pos_r;
    size_nxt = size_r;
    hi_nxt   = hi_r;
    seq_nxt  = seq_r;
    rcrc_nxt = rcrc_r;
    crc_nxt  = crc_r;
    err_nxt  = err_r;
    ok       = 1'b1;
    crc_fold = 1'b0;
    done     = 1'b0;
    boff     = '0;
    bval     = '0;
    status   = ST_ACCEPT;

    if (in_body) begin
      boff     = 12'(pos_r - HDR);
      bval     = b;
      crc_fold = 1'b1;
    end else if (pos_r < HDR) begin
      crc_fold = 1'b1;
      case (pos_r[2:0])
        3'd0: begin
          ok      = (b == START_BYTE);
          crc_nxt = CRC_INIT;
        end
        3'd1: seq_nxt = {8'h00, b};
        3'd2: seq_nxt = {b, seq_r[7:0]};
        3'd3: begin
          size_nxt = {5'd0, b};
          hi_nxt   = 1'b0;
        end
        3'd4: begin
          size_nxt = {b[4:0], size_r[7:0]};
          hi_nxt   = hi_r | (|b[7:5]);
        end
        3'd5: hi_nxt = hi_r | (|b);
        3'd6: begin
          hi_nxt = hi_r | (|b);
          ok     = !hi_nxt && (size_r != '0) && (size_r <= max_r) &&
                   (17'(size_r) <= MAX_BODY_W);
        end
        default: ok = (b == TOKEN_BYTE);
      endcase
    end else if (pos_r == pos_end) begin
      rcrc_nxt = {8'h00, b};
    end else begin
      rcrc_nxt = {b, rcrc_r[7:0]};
      ok       = (crc_r == rcrc_nxt);
      done     = 1'b1;
    end

    if (ok) begin
      if (crc_fold) begin
        crc_nxt = crc_byte(crc_nxt, b);
      end
      pos_nxt = done ? '0 : pos_r + 1'b1;
      if (done) begin
        status = ST_DONE;
      end
    end else begin
      status   = ST_ERROR;
      err_nxt  = 13'(pos_r);
      pos_nxt  = '0;
      size_nxt = '0;
      hi_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r   <= CFG_RESET;
      pos_r   <= '0;
      size_r  <= '0;
      hi_r    <= 1'b0;
      seq_r   <= '0;
      rcrc_r  <= CRC_INIT;
      crc_r   <= CRC_INIT;
      err_r   <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
      if (in_tready) begin
        s1_v_r <= in_tvalid;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
      if (fire) begin
        pos_r  <= pos_nxt;
        size_r <= size_nxt;
        hi_r   <= hi_nxt;
        seq_r  <= seq_nxt;
        rcrc_r <= rcrc_nxt;
        crc_r  <= crc_nxt;
        err_r  <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
    if (fire) begin
      out_data_r <= {2'b00, err_nxt, size_nxt, seq_nxt, bval, boff};
      out_user_r <= {in_body, status};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- hdl/cfmr_checker.sv -----
// Port-level checker for the CRC-16 framed message receiver, with its bind statement.
// Depends on cfmr_pkg and crc16_framed_message_receiver.
module cfmr_port_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cfmr_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [cfmr_pkg::OUT_USER_W-1:0] out_tuser
);
  import cfmr_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result transaction changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser[1:0] == ST_ACCEPT) || (out_tuser[1:0] == ST_ERROR) ||
                   (out_tuser[1:0] == ST_DONE))
    else $error("undefined status code");

  a_body_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == ST_ACCEPT)
    else $error("body byte reported with error or completion");

  a_nonbody_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tdata[19:0] == 20'd0)
    else $error("non-body result carries body offset or byte");

  a_error_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] == ST_ERROR) |-> out_tdata[48:36] == 13'd0)
    else $error("body length not cleared on error");

endmodule

bind crc16_framed_message_receiver cfmr_port_checker u_cfmr_port_checker (.*);

// ----- dv/cfmr_checker.sv -----
// Checker for the CRC-16 framed message receiver: watches the byte, result and register ports,
// predicts each result from its own frame decoder and compares it field by field.
// Depends on cfmr_pkg; the failure and pending counts go back to the testbench top.
module cfmr_checker #(
  parameter int MAX_BODY = cfmr_pkg::MAX_BODY_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [cfmr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [cfmr_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [cfmr_pkg::OUT_USER_W-1:0] out_tuser,
  input  logic                            cfg_wr_en,
  input  logic [cfmr_pkg::CFG_W-1:0]      cfg_wr_data,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfmr_pkg::*;

  typedef struct packed {
    status_t     status;
    logic        body_valid;
    logic [11:0] body_offset;
    logic [7:0]  body_byte;
    logic [15:0] seq_num;
    logic [12:0] body_len;
    logic [12:0] err_pos;
  } msg_result_t;

  logic [12:0] max_size_reg = CFG_RESET;
  logic [31:0] byte_pos = '0;
  logic [31:0] size_acc = '0;
  logic [15:0] seq_acc = '0;
  logic [15:0] crc_rx = CRC_INIT;
  logic [15:0] crc_run = CRC_INIT;
  logic [12:0] err_at = '0;
  msg_result_t expected_results[$];
  int errors = 0;

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  function automatic msg_result_t decode_byte(input logic [7:0] b);
    msg_result_t r;
    logic [63:0] p;
    logic [63:0] body_end;
    int unsigned limit;
    logic ok;
    r = '0;
    r.status = ST_ACCEPT;
    ok = 1'b1;
    p = {32'h0, byte_pos};
    body_end = {32'h0, size_acc} + 64'(HEADER_LEN);
    if (p >= 64'(HEADER_LEN) && p < body_end) begin
      r.body_valid = 1'b1;
      r.body_offset = 12'(byte_pos - HEADER_LEN);
      r.body_byte = b;
    end else if (p == 0) begin
      ok = (b == START_BYTE);
      crc_run = CRC_INIT;
    end else if (p == 1) begin
      seq_acc = {8'h00, b};
    end else if (p == 2) begin
      seq_acc[15:8] = b;
    end else if (p == 3) begin
      size_acc = {24'h0, b};
    end else if (p == 4) begin
      size_acc = size_acc + {16'h0, b, 8'h00};
    end else if (p == 5) begin
      size_acc = size_acc + {8'h0, b, 16'h0000};
    end else if (p == 6) begin
      limit = (max_size_reg > MAX_BODY) ? MAX_BODY : max_size_reg;
      size_acc = size_acc + {b, 24'h0};
      ok = (size_acc != 0) && (size_acc <= limit);
    end else if (p == 7) begin
      ok = (b == TOKEN_BYTE);
    end else if (p == body_end) begin
      crc_rx = {8'h00, b};
    end else if (p == body_end + 1) begin
      crc_rx[15:8] = b;
      ok = (crc_run == crc_rx);
    end

    if (ok) begin
      if (p < {32'h0, size_acc} + 64'(HEADER_LEN)) crc_run = crc16_update(crc_run, b);
      byte_pos = byte_pos + 1;
    end else begin
      r.status = ST_ERROR;
      err_at = byte_pos[12:0];
      byte_pos = '0;
      size_acc = '0;
    end
    if ({32'h0, byte_pos} == {32'h0, size_acc} + 64'(HEADER_LEN + 2)) begin
      r.status = ST_DONE;
      byte_pos = '0;
    end

    r.seq_num = seq_acc;
    r.body_len = size_acc[12:0];
    r.err_pos = err_at;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (errors < 100)
      $display("ERROR %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    msg_result_t got;
    msg_result_t want;
    if (!rst_n) begin
      max_size_reg = CFG_RESET;
      byte_pos = '0;
      size_acc = '0;
      seq_acc = '0;
      crc_rx = CRC_INIT;
      crc_run = CRC_INIT;
      err_at = '0;
      expected_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = status_t'(out_tuser[1:0]);
        got.body_valid = out_tuser[2];
        got.body_offset = out_tdata[11:0];
        got.body_byte = out_tdata[19:12];
        got.seq_num = out_tdata[35:20];
        got.body_len = out_tdata[48:36];
        got.err_pos = out_tdata[61:49];
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", got.status, 0);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.body_valid !== want.body_valid)
            report_mismatch("body_valid", got.body_valid, want.body_valid);
          if (got.body_offset !== want.body_offset)
            report_mismatch("body_offset", got.body_offset, want.body_offset);
          if (got.body_byte !== want.body_byte)
            report_mismatch("body_byte", got.body_byte, want.body_byte);
          if (got.seq_num !== want.seq_num)
            report_mismatch("sequence_number", got.seq_num, want.seq_num);
          if (got.body_len !== want.body_len)
            report_mismatch("body_length", got.body_len, want.body_len);
          if (got.err_pos !== want.err_pos)
            report_mismatch("error_position", got.err_pos, want.err_pos);
        end
      end
      if (in_tvalid && in_tready) expected_results.push_back(decode_byte(in_tdata));
      if (cfg_wr_en) max_size_reg = cfg_wr_data;
    end
    pending <= expected_results.size();
    fail_count <= errors;
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for the CRC-16 framed message receiver: clock, reset, framed byte stimulus
// with bursty sending and result stalls, max body size settings, and the verdict.
// Depends on cfmr_pkg, crc16_framed_message_receiver and cfmr_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cfmr_pkg::*;

  localparam int MAX_BODY = MAX_BODY_DEF;
  localparam int PHASE_BYTES = 230;

  typedef enum int {
    FR_GOOD,
    FR_BAD_START,
    FR_BAD_SIZE,
    FR_BAD_TOKEN,
    FR_BAD_CRC,
    FR_CUT,
    FR_NOISE
  } frame_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [7:0] rx_byte
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [11:0] offset, [19:12] byte, [35:20] seq,
                                          // [48:36] length, [61:49] error position
  logic [OUT_USER_W-1:0] out_tuser;       // [1:0] status, [2] body_valid
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;
  int                    fail_count;
  int                    pending;

  logic [12:0] max_size_set = CFG_RESET;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          stall_mode = 0;
  int          mode_left = 0;
  int          stall_run = 0;

  always #5 clk = ~clk;

  crc16_framed_message_receiver #(.MAX_BODY(MAX_BODY)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  cfmr_checker #(.MAX_BODY(MAX_BODY)) chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // result side: free running, random stalls or bursts of stall cycles
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (stall_run == 0) begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) stall_run <= $urandom_range(1, 12);
        end else begin
          out_tready <= 1'b0;
          stall_run <= stall_run - 1;
        end
      end
    endcase
  end

  function automatic int cur_limit();
    return (max_size_set > MAX_BODY) ? MAX_BODY : int'(max_size_set);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_frame(input frame_kind_t kind, input int body_len,
                            input logic [15:0] seq, input int fill);
    logic [31:0] size_field;
    logic [63:0] hdr;
    logic [15:0] crc;
    logic [7:0]  frame_q[$];
    int          keep;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
    end else begin
      size_field = body_len;
      if (kind == FR_BAD_SIZE) begin
        case ($urandom_range(0, 2))
          0: size_field = '0;
          1: size_field = cur_limit() + 1;
          default: size_field = $urandom | 32'h0000_2000;
        endcase
      end
      hdr = {TOKEN_BYTE, size_field, seq, START_BYTE};
      if (kind == FR_BAD_START) begin
        hdr[7:0] = 8'($urandom);
        if (hdr[7:0] == START_BYTE) hdr[7] = ~hdr[7];
      end
      if (kind == FR_BAD_TOKEN) hdr[63:56] = hdr[63:56] ^ 8'($urandom_range(1, 255));
      for (int i = 0; i < 8; i++) frame_q.push_back(hdr[8*i +: 8]);
      if (kind == FR_GOOD || kind == FR_BAD_CRC || kind == FR_CUT) begin
        for (int i = 0; i < body_len; i++)
          frame_q.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
        crc = CRC_INIT;
        foreach (frame_q[i]) begin
          crc = crc ^ {8'h00, frame_q[i]};
          repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        if (kind == FR_BAD_CRC) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
      end
      case (kind)
        FR_BAD_SIZE:  keep = 7;
        FR_BAD_TOKEN: keep = 8;
        FR_CUT:       keep = $urandom_range(1, frame_q.size() - 1);
        default:      keep = frame_q.size();
      endcase
      while (frame_q.size() > keep) void'(frame_q.pop_back());
    end
    foreach (frame_q[i]) send_byte(frame_q[i]);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_max_size(input logic [12:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_size_set = v;
  endtask

  initial begin
    logic [12:0] settings[8];
    frame_kind_t kind;
    int          pick;
    int          hi;
    int          len;
    int          phase_end;
    settings = '{CFG_RESET, 13'd0, 13'd1, 13'h1FFF, 13'($urandom_range(2, 64)),
                 13'($urandom_range(65, 4095)), 13'd4096, 13'($urandom_range(1, 8191))};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(FR_GOOD, 1, 16'hFFFF, 8'hFF);
    send_frame(FR_BAD_CRC, 1, 16'h0000, 8'h00);

    for (int p = 0; p < 8; p++) begin
      if (p > 0) begin
        drain();
        write_max_size(settings[p]);
      end
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        kind = (pick < 60) ? FR_GOOD : (pick < 68) ? FR_BAD_CRC : (pick < 76) ? FR_BAD_SIZE :
               (pick < 82) ? FR_BAD_TOKEN : (pick < 88) ? FR_BAD_START :
               (pick < 94) ? FR_CUT : FR_NOISE;
        hi = (cur_limit() < 24) ? cur_limit() : 24;
        if (hi < 1) hi = 1;
        len = $urandom_range(1, hi);
        if (cur_limit() >= 1 && cur_limit() <= 64 && $urandom_range(0, 9) == 0) len = cur_limit();
        send_frame(kind, len, 16'($urandom), -1);
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("PASS crc16_framed_message_receiver");
    end else begin
      $display("FAIL crc16_framed_message_receiver");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL crc16_framed_message_receiver");
    $finish;
  end

endmodule
